// File: src/abt_pkg.sv
// Package for the address ban table: request and result structs, opcodes,
// sequencer states and fixed field widths. No dependencies.
package abt_pkg;

  localparam int unsigned ExpW = 48;
  localparam int unsigned DurW = 40;
  localparam logic [ExpW-1:0] ExpMax = {ExpW{1'b1}};
  localparam logic [DurW-1:0] DurReset = 40'd31536000;

  typedef enum logic [3:0] {
    OP_BAN_ADDR   = 4'd0,
    OP_BAN_SUB    = 4'd1,
    OP_UNBAN_ADDR = 4'd2,
    OP_UNBAN_SUB  = 4'd3,
    OP_QUERY      = 4'd4,
    OP_QUERY_ADDR = 4'd5,
    OP_QUERY_SUB  = 4'd6,
    OP_SWEEP      = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SUB,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] address_hi;
    logic [63:0] address_lo;
    logic [7:0]  prefix_length;
    logic [39:0] duration;
    logic [47:0] now;
  } req_t;

  typedef struct packed {
    logic       banned;
    logic       changed;
    logic       status;
    logic [6:0] removed_count;
    logic [6:0] address_count;
    logic [4:0] subnet_count;
  } res_t;

  // Prefix mask over the whole 128-bit address; prefix already capped at 128.
  function automatic logic [127:0] prefix_mask(input logic [7:0] p);
    logic [127:0] m;
    m = ~(128'h0 >> 0);
    if (p == 8'd0) m = '0;
    else m = ~({128{1'b1}} >> p);
    return m;
  endfunction

endpackage

// File: src/address_ban_table_with_expiry_core.sv
// Top level of the address ban table with expiry.
// Depends on abt_pkg for the request/result structs, opcodes and states.
//
// Channel  | Ports                          | Handshake
// request  | start_i, req_i, busy_o         | taken when start_i && !busy_o
// result   | done_o, res_o                  | one cycle strobe, no stall
// config   | cfg_we_i, cfg_data_i           | written when cfg_we_i
//
// An item scans every address entry, then every subnet entry, one entry per
// cycle through a single shared compare unit, then passes a write state and a
// result state. Clear and unknown operations skip the scan and the write state.
// The address table is read in the cycle before its entry is examined, through a registered read port.
// Reset empties both tables at once through their valid bits.
module address_ban_table_with_expiry_core #(
  parameter int unsigned ADDR_ENTRIES   = 64,
  parameter int unsigned SUBNET_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  abt_pkg::req_t    req_i,
  output logic             busy_o,
  output logic             done_o,
  output abt_pkg::res_t    res_o,
  input  logic             cfg_we_i,
  input  logic [39:0]      cfg_data_i
);

  localparam int unsigned AW = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
  localparam int unsigned SW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
  localparam int unsigned ACW = $clog2(ADDR_ENTRIES + 1);
  localparam int unsigned SCW = $clog2(SUBNET_ENTRIES + 1);
  localparam int unsigned RCW = $clog2(ADDR_ENTRIES + SUBNET_ENTRIES + 1);

  // Entry stores; only the valid bits are reset.
  logic [127:0]              akey_mem [ADDR_ENTRIES];
  logic [abt_pkg::ExpW-1:0]  aexp_mem [ADDR_ENTRIES];
  logic [127:0]              sbase_mem [SUBNET_ENTRIES];
  logic [7:0]                spre_mem [SUBNET_ENTRIES];
  logic [abt_pkg::ExpW-1:0]  sexp_mem [SUBNET_ENTRIES];
  logic [ADDR_ENTRIES-1:0]   avalid_q;
  logic [SUBNET_ENTRIES-1:0] svalid_q;

  abt_pkg::state_e state_q, state_d;
  abt_pkg::req_t   req_q;
  logic [39:0]     maxdur_q;
  logic [AW-1:0]   aidx_q, aidx_d;
  logic [SW-1:0]   sidx_q, sidx_d;
  logic            hit_q, hit_d, free_q, free_d;
  logic [AW-1:0]   ahit_q, ahit_d, afree_q, afree_d;
  logic [SW-1:0]   shit_q, shit_d, sfree_q, sfree_d;
  logic            banned_q, banned_d;
  logic [RCW-1:0]  rem_q, rem_d;
  logic [ACW-1:0]  acnt_q, acnt_d;
  logic [SCW-1:0]  scnt_q, scnt_d;
  logic            chg_q, chg_d, stat_q, stat_d;
  logic            aclr, sclr, awr, swr;
  logic [abt_pkg::ExpW-1:0] cur_exp;
  logic [AW-1:0]   ard_addr;
  logic [127:0]    akey_rd_q;
  logic [abt_pkg::ExpW-1:0] aexp_rd_q;

  logic [7:0]   pre_c;
  logic [127:0] addr_c, base_c, emask_c;
  logic [abt_pkg::ExpW-1:0] nu_c;
  logic [39:0]  lim_c, dur_c;
  logic [48:0]  sum_c;
  logic         is_addr_op, is_sub_op, is_q;
  logic         a_v, a_eq, a_exp, s_v, s_eq_key, s_in, s_exp;

  assign addr_c = {req_q.address_hi, req_q.address_lo};
  assign pre_c  = (req_q.prefix_length > 8'd128) ? 8'd128 : req_q.prefix_length;
  assign base_c = addr_c & abt_pkg::prefix_mask(pre_c);
  assign lim_c  = (maxdur_q == '0) ? 40'd1 : maxdur_q;
  assign dur_c  = (req_q.duration > lim_c) ? lim_c : req_q.duration;
  assign sum_c  = {1'b0, req_q.now} + {9'd0, dur_c};
  assign nu_c   = (req_q.duration == '0) ? '0 :
                  (sum_c[48] ? abt_pkg::ExpMax : sum_c[47:0]);

  // Shared compare unit: one address entry and one subnet entry examined.
  assign a_v   = avalid_q[aidx_q];
  assign a_eq  = akey_rd_q == addr_c;
  assign a_exp = (aexp_rd_q != '0) && (req_q.now >= aexp_rd_q);
  assign s_v   = svalid_q[sidx_q];
  assign emask_c  = abt_pkg::prefix_mask(spre_mem[sidx_q]);
  assign s_eq_key = (spre_mem[sidx_q] == pre_c) && (sbase_mem[sidx_q] == base_c);
  assign s_in     = (addr_c & emask_c) == sbase_mem[sidx_q];
  assign s_exp = (sexp_mem[sidx_q] != '0) && (req_q.now >= sexp_mem[sidx_q]);

  // The read port fetches the entry that the next cycle examines; in the write
  // cycle that is the matching entry.
  assign ard_addr = (state_d == abt_pkg::ST_WRITE) ? ahit_d : aidx_d;

  always_comb begin
    is_addr_op = 1'b0;
    is_sub_op  = 1'b0;
    is_q       = 1'b0;
    case (abt_pkg::op_e'(req_q.operation))
      abt_pkg::OP_BAN_ADDR, abt_pkg::OP_UNBAN_ADDR: is_addr_op = 1'b1;
      abt_pkg::OP_BAN_SUB, abt_pkg::OP_UNBAN_SUB:   is_sub_op = 1'b1;
      abt_pkg::OP_QUERY, abt_pkg::OP_QUERY_ADDR,
      abt_pkg::OP_QUERY_SUB:                        is_q = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    aidx_d = aidx_q; sidx_d = sidx_q;
    hit_d = hit_q; free_d = free_q;
    ahit_d = ahit_q; afree_d = afree_q; shit_d = shit_q; sfree_d = sfree_q;
    banned_d = banned_q; rem_d = rem_q;
    acnt_d = acnt_q; scnt_d = scnt_q;
    chg_d = chg_q; stat_d = stat_q;
    aclr = 1'b0; sclr = 1'b0; awr = 1'b0; swr = 1'b0;
    cur_exp = '0;
    case (state_q)
      abt_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = abt_pkg::ST_ADDR;
          aidx_d = '0; sidx_d = '0;
          hit_d = 1'b0; free_d = 1'b0; banned_d = 1'b0; rem_d = '0;
          chg_d = 1'b0; stat_d = 1'b0;
          acnt_d = '0; scnt_d = '0;
        end
      end
      abt_pkg::ST_ADDR: begin
        if (a_v) acnt_d = acnt_q + 1'b1;
        case (abt_pkg::op_e'(req_q.operation))
          abt_pkg::OP_BAN_ADDR, abt_pkg::OP_UNBAN_ADDR: begin
            if (a_v && a_eq && !hit_q) begin
              hit_d = 1'b1; ahit_d = aidx_q;
            end else if (!a_v && !free_q) begin
              free_d = 1'b1; afree_d = aidx_q;
            end
          end
          abt_pkg::OP_QUERY, abt_pkg::OP_QUERY_ADDR: begin
            if (a_v && a_eq && !a_exp) banned_d = 1'b1;
          end
          abt_pkg::OP_SWEEP: begin
            if (a_v && a_exp) begin
              aclr = 1'b1; rem_d = rem_q + 1'b1; acnt_d = acnt_q;
            end
          end
          default: ;
        endcase
        if (aidx_q == AW'(ADDR_ENTRIES - 1)) state_d = abt_pkg::ST_SUB;
        else aidx_d = aidx_q + 1'b1;
      end
      abt_pkg::ST_SUB: begin
        if (s_v) scnt_d = scnt_q + 1'b1;
        case (abt_pkg::op_e'(req_q.operation))
          abt_pkg::OP_BAN_SUB: begin
            if (s_v && s_eq_key && !hit_q) begin
              hit_d = 1'b1; shit_d = sidx_q;
            end else if (!s_v && !free_q) begin
              free_d = 1'b1; sfree_d = sidx_q;
            end
          end
          abt_pkg::OP_UNBAN_SUB: begin
            if (s_v && s_eq_key) begin
              sclr = 1'b1; chg_d = 1'b1; scnt_d = scnt_q;
            end
          end
          abt_pkg::OP_QUERY, abt_pkg::OP_QUERY_SUB: begin
            if (s_v && s_in && !s_exp) banned_d = 1'b1;
          end
          abt_pkg::OP_SWEEP: begin
            if (s_v && s_exp) begin
              sclr = 1'b1; rem_d = rem_q + 1'b1; scnt_d = scnt_q;
            end
          end
          default: ;
        endcase
        if (sidx_q == SW'(SUBNET_ENTRIES - 1)) state_d = abt_pkg::ST_WRITE;
        else sidx_d = sidx_q + 1'b1;
      end
      abt_pkg::ST_WRITE: begin
        state_d = abt_pkg::ST_DONE;
        case (abt_pkg::op_e'(req_q.operation))
          abt_pkg::OP_BAN_ADDR, abt_pkg::OP_BAN_SUB: begin
            cur_exp = (req_q.operation == abt_pkg::OP_BAN_ADDR) ?
                      aexp_rd_q : sexp_mem[shit_q];
            if (hit_q) begin
              if (nu_c == '0 || (cur_exp != '0 && nu_c > cur_exp)) begin
                chg_d = 1'b1;
                awr = (req_q.operation == abt_pkg::OP_BAN_ADDR);
                swr = !awr;
              end
            end else if (free_q) begin
              chg_d = 1'b1;
              awr = (req_q.operation == abt_pkg::OP_BAN_ADDR);
              swr = !awr;
              if (awr) acnt_d = acnt_q + 1'b1;
              else scnt_d = scnt_q + 1'b1;
            end else begin
              stat_d = 1'b1;
            end
          end
          abt_pkg::OP_UNBAN_ADDR: begin
            if (hit_q) begin
              aclr = 1'b1; chg_d = 1'b1; acnt_d = acnt_q - 1'b1;
            end
          end
          abt_pkg::OP_SWEEP: chg_d = rem_q != '0;
          default: ;
        endcase
      end
      abt_pkg::ST_DONE: state_d = abt_pkg::ST_IDLE;
      default: state_d = abt_pkg::ST_IDLE;
    endcase
    // Clear and unknown codes need no scan.
    if (state_q == abt_pkg::ST_ADDR && !is_addr_op && !is_sub_op && !is_q &&
        req_q.operation != abt_pkg::OP_SWEEP) begin
      state_d = abt_pkg::ST_DONE;
      chg_d = (req_q.operation == abt_pkg::OP_CLEAR);
      acnt_d = '0; scnt_d = '0;
      if (req_q.operation != abt_pkg::OP_CLEAR) begin
        acnt_d = ACW'($countones(avalid_q));
        scnt_d = SCW'($countones(svalid_q));
      end
    end
  end

  logic do_clear;
  assign do_clear = state_q == abt_pkg::ST_ADDR && req_q.operation == abt_pkg::OP_CLEAR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= abt_pkg::ST_IDLE;
      maxdur_q <= abt_pkg::DurReset;
      avalid_q <= '0;
      svalid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) maxdur_q <= cfg_data_i;
      if (do_clear) begin
        avalid_q <= '0;
        svalid_q <= '0;
      end else begin
        if (aclr) avalid_q[(state_q == abt_pkg::ST_WRITE) ? ahit_q : aidx_q] <= 1'b0;
        if (sclr) svalid_q[sidx_q] <= 1'b0;
        if (awr && !hit_q) avalid_q[afree_q] <= 1'b1;
        if (swr && !hit_q) svalid_q[sfree_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == abt_pkg::ST_IDLE && start_i) req_q <= req_i;
    aidx_q <= aidx_d; sidx_q <= sidx_d;
    hit_q <= hit_d; free_q <= free_d;
    ahit_q <= ahit_d; afree_q <= afree_d; shit_q <= shit_d; sfree_q <= sfree_d;
    banned_q <= banned_d; rem_q <= rem_d;
    acnt_q <= acnt_d; scnt_q <= scnt_d;
    chg_q <= chg_d; stat_q <= stat_d;
  end

  always_ff @(posedge clk_i) begin
    akey_rd_q <= akey_mem[ard_addr];
    aexp_rd_q <= aexp_mem[ard_addr];
    if (awr) begin
      if (!hit_q) akey_mem[afree_q] <= addr_c;
      aexp_mem[hit_q ? ahit_q : afree_q] <= nu_c;
    end
    if (swr) begin
      if (!hit_q) begin
        sbase_mem[sfree_q] <= base_c;
        spre_mem[sfree_q]  <= pre_c;
      end
      sexp_mem[hit_q ? shit_q : sfree_q] <= nu_c;
    end
  end

  assign busy_o = state_q != abt_pkg::ST_IDLE;
  assign done_o = state_q == abt_pkg::ST_DONE;
  always_comb begin
    res_o = '0;
    res_o.banned  = banned_q;
    res_o.changed = chg_q;
    res_o.status  = stat_q;
    res_o.removed_count = (rem_q > RCW'(127)) ? 7'd127 : 7'(rem_q);
    res_o.address_count = (acnt_q > ACW'(127)) ? 7'd127 : 7'(acnt_q);
    res_o.subnet_count  = (scnt_q > SCW'(31)) ? 5'd31 : 5'(scnt_q);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.status && res_o.changed)) else $error("full and changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abt_pkg::ST_IDLE) |-> $stable(avalid_q) || $past(do_clear))
    else $error("table moved while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.removed_count != 7'd0) |-> res_o.changed)
    else $error("sweep removed without change");

endmodule

// File: sim/tb_address_ban_table_with_expiry_core.sv
// Testbench for the address ban table with expiry: directed and random requests,
// a built-in predictor of both tables, and a result checker. Depends on abt_pkg.
module tb_address_ban_table_with_expiry_core;

  localparam int NA = 64;
  localparam int NS = 16;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  abt_pkg::req_t req_i = '0;
  logic busy_o, done_o;
  abt_pkg::res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [39:0] cfg_data_i = '0;

  address_ban_table_with_expiry_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [39:0]  max_dur;
  bit           a_vld [NA];
  logic [127:0] a_key [NA];
  logic [47:0]  a_exp [NA];
  bit           s_vld [NS];
  logic [127:0] s_base [NS];
  logic [7:0]   s_pre [NS];
  logic [47:0]  s_exp [NS];

  abt_pkg::req_t pending_q[$];
  abt_pkg::res_t expected_q[$];
  int   sender_idle_pct = 0;
  bit   failed = 1'b0;
  longint cycles = 0;
  // Pool of addresses so that repeats and subnet hits are frequent.
  logic [127:0] addr_pool [8];

  function automatic logic [127:0] pmask(input logic [7:0] p);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 128; i++) if (i < p) m[127-i] = 1'b1;
    return m;
  endfunction

  function automatic bit expired(input logic [47:0] exp_at, input logic [47:0] now);
    return exp_at != 0 && now >= exp_at;
  endfunction

  function automatic logic [47:0] ban_expiry(input logic [47:0] now, input logic [39:0] dur);
    logic [39:0] lim;
    logic [48:0] t;
    if (dur == 0) return '0;
    lim = (max_dur == 0) ? 40'd1 : max_dur;
    if (dur > lim) dur = lim;
    t = {1'b0, now} + dur;
    return t[48] ? abt_pkg::ExpMax : t[47:0];
  endfunction

  function automatic abt_pkg::res_t predict_ban_table(input abt_pkg::req_t r);
    abt_pkg::res_t o;
    logic [7:0] pre;
    logic [127:0] addr, base;
    logic [47:0] nu;
    int hit, freei, removed, ac, sc;
    o = '0;
    hit = -1;
    freei = -1;
    removed = 0;
    pre = (r.prefix_length > 128) ? 8'd128 : r.prefix_length;
    addr = {r.address_hi, r.address_lo};
    base = addr & pmask(pre);
    case (r.operation)
      abt_pkg::OP_BAN_ADDR, abt_pkg::OP_UNBAN_ADDR: begin
        for (int i = 0; i < NA; i++) begin
          if (a_vld[i]) begin
            if (hit < 0 && a_key[i] == addr) hit = i;
          end else if (freei < 0) freei = i;
        end
        if (r.operation == abt_pkg::OP_BAN_ADDR) begin
          nu = ban_expiry(r.now, r.duration);
          if (hit >= 0) begin
            if (nu == 0 || (a_exp[hit] != 0 && nu > a_exp[hit])) begin
              a_exp[hit] = nu;
              o.changed = 1'b1;
            end
          end else if (freei >= 0) begin
            a_vld[freei] = 1'b1;
            a_key[freei] = addr;
            a_exp[freei] = nu;
            o.changed = 1'b1;
          end else o.status = 1'b1;
        end else if (hit >= 0) begin
          a_vld[hit] = 1'b0;
          o.changed = 1'b1;
        end
      end
      abt_pkg::OP_BAN_SUB, abt_pkg::OP_UNBAN_SUB: begin
        for (int i = 0; i < NS; i++) begin
          if (s_vld[i]) begin
            if (s_pre[i] == pre && s_base[i] == base) begin
              if (r.operation == abt_pkg::OP_UNBAN_SUB) begin
                s_vld[i] = 1'b0;
                o.changed = 1'b1;
              end else if (hit < 0) hit = i;
            end
          end else if (freei < 0) freei = i;
        end
        if (r.operation == abt_pkg::OP_BAN_SUB) begin
          nu = ban_expiry(r.now, r.duration);
          if (hit >= 0) begin
            if (nu == 0 || (s_exp[hit] != 0 && nu > s_exp[hit])) begin
              s_exp[hit] = nu;
              o.changed = 1'b1;
            end
          end else if (freei >= 0) begin
            s_vld[freei] = 1'b1;
            s_base[freei] = base;
            s_pre[freei] = pre;
            s_exp[freei] = nu;
            o.changed = 1'b1;
          end else o.status = 1'b1;
        end
      end
      abt_pkg::OP_QUERY, abt_pkg::OP_QUERY_ADDR, abt_pkg::OP_QUERY_SUB: begin
        if (r.operation != abt_pkg::OP_QUERY_SUB)
          for (int i = 0; i < NA; i++)
            if (a_vld[i] && a_key[i] == addr && !expired(a_exp[i], r.now)) o.banned = 1'b1;
        if (r.operation != abt_pkg::OP_QUERY_ADDR)
          for (int i = 0; i < NS; i++)
            if (s_vld[i] && !expired(s_exp[i], r.now) &&
                (addr & pmask(s_pre[i])) == s_base[i]) o.banned = 1'b1;
      end
      abt_pkg::OP_SWEEP: begin
        for (int i = 0; i < NA; i++)
          if (a_vld[i] && expired(a_exp[i], r.now)) begin
            a_vld[i] = 1'b0;
            removed++;
          end
        for (int i = 0; i < NS; i++)
          if (s_vld[i] && expired(s_exp[i], r.now)) begin
            s_vld[i] = 1'b0;
            removed++;
          end
        o.changed = removed > 0;
        o.removed_count = 7'(removed);
      end
      abt_pkg::OP_CLEAR: begin
        for (int i = 0; i < NA; i++) a_vld[i] = 1'b0;
        for (int i = 0; i < NS; i++) s_vld[i] = 1'b0;
        o.changed = 1'b1;
      end
      default: ;
    endcase
    ac = 0;
    sc = 0;
    for (int i = 0; i < NA; i++) ac += a_vld[i];
    for (int i = 0; i < NS; i++) sc += s_vld[i];
    o.address_count = 7'(ac);
    o.subnet_count = 5'(sc);
    return o;
  endfunction

  // Driver: start stays high while requests are queued and the sender is not idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_q.push_back(predict_ban_table(req_i));
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        req_i <= pending_q[0];
      end else if (!(start_i && busy_o)) begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        failed = 1'b1;
      end else begin
        abt_pkg::res_t e;
        e = expected_q.pop_front();
        if (res_o.banned !== e.banned) begin
          $error("banned exp %0d got %0d", e.banned, res_o.banned); failed = 1'b1;
        end
        if (res_o.changed !== e.changed) begin
          $error("changed exp %0d got %0d", e.changed, res_o.changed); failed = 1'b1;
        end
        if (res_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, res_o.status); failed = 1'b1;
        end
        if (res_o.removed_count !== e.removed_count) begin
          $error("removed_count exp %0d got %0d", e.removed_count, res_o.removed_count);
          failed = 1'b1;
        end
        if (res_o.address_count !== e.address_count) begin
          $error("address_count exp %0d got %0d", e.address_count, res_o.address_count);
          failed = 1'b1;
        end
        if (res_o.subnet_count !== e.subnet_count) begin
          $error("subnet_count exp %0d got %0d", e.subnet_count, res_o.subnet_count);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic abt_pkg::req_t make_request(input abt_pkg::op_e op,
                                                 input logic [127:0] a,
                                                 input logic [7:0] p, input logic [39:0] d,
                                                 input logic [47:0] t);
    abt_pkg::req_t r;
    r.operation = op;
    {r.address_hi, r.address_lo} = a;
    r.prefix_length = p;
    r.duration = d;
    r.now = t;
    return r;
  endfunction

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic abt_pkg::req_t random_request(input logic [47:0] t);
    abt_pkg::req_t r;
    logic [127:0] a;
    logic [39:0] d;
    int k;
    k = $urandom_range(99);
    a = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(7)] : rand_addr();
    if ($urandom_range(3) == 0) a = a ^ (128'(1) << $urandom_range(127));
    case ($urandom_range(3))
      0: d = 0;
      1: d = 40'($urandom_range(200));
      2: d = 40'({$urandom, $urandom});
      default: d = 40'($urandom_range(3000));
    endcase
    r = make_request(abt_pkg::OP_BAN_ADDR, a, 8'($urandom_range(140)), d, t);
    if ($urandom_range(9) == 0) r.prefix_length = 8'($urandom);
    if (k < 25) r.operation = abt_pkg::OP_BAN_ADDR;
    else if (k < 40) r.operation = abt_pkg::OP_BAN_SUB;
    else if (k < 47) r.operation = abt_pkg::OP_UNBAN_ADDR;
    else if (k < 52) r.operation = abt_pkg::OP_UNBAN_SUB;
    else if (k < 70) r.operation = abt_pkg::OP_QUERY;
    else if (k < 79) r.operation = abt_pkg::OP_QUERY_ADDR;
    else if (k < 88) r.operation = abt_pkg::OP_QUERY_SUB;
    else if (k < 95) r.operation = abt_pkg::OP_SWEEP;
    else if (k < 97) r.operation = abt_pkg::OP_CLEAR;
    else r.operation = abt_pkg::op_e'(4'($urandom_range(15, 9)));
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_max_duration(input logic [39:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_dur = v;
  endtask

  initial begin
    logic [47:0] t;
    logic [127:0] a;
    max_dur = abt_pkg::DurReset;
    for (int i = 0; i < NA; i++) a_vld[i] = 1'b0;
    for (int i = 0; i < NS; i++) s_vld[i] = 1'b0;
    for (int i = 0; i < 8; i++) addr_pool[i] = rand_addr();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, each operation, and the special cases.
    a = rand_addr();
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, '0, 0, 0, 0));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, '1, 8'hFF, 40'hFF_FFFF_FFFF, '1));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, a, 0, 100, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, a, 0, 50, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, a, 0, 0, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, a, 0, 0, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_QUERY_ADDR, a, 0, 0, 5000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_SUB, a, 8'd200, 10, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_SUB, a, 8'd0, 10, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_SUB, a, 8'd37, 0, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_BAN_SUB, a ^ 128'h1, 8'd37, 0, 1000));
    pending_q.push_back(make_request(abt_pkg::OP_QUERY_SUB, ~a, 0, 0, 1005));
    pending_q.push_back(make_request(abt_pkg::OP_QUERY, ~a, 0, 0, 1010));
    pending_q.push_back(make_request(abt_pkg::OP_SWEEP, '0, 0, 0, 1010));
    pending_q.push_back(make_request(abt_pkg::OP_UNBAN_SUB, a, 8'd37, 0, 0));
    pending_q.push_back(make_request(abt_pkg::OP_UNBAN_SUB, a, 8'd37, 0, 0));
    pending_q.push_back(make_request(abt_pkg::OP_UNBAN_ADDR, a, 0, 0, 0));
    pending_q.push_back(make_request(abt_pkg::OP_UNBAN_ADDR, a, 0, 0, 0));
    pending_q.push_back(make_request(abt_pkg::op_e'(4'd9), a, 0, 0, 0));
    pending_q.push_back(make_request(abt_pkg::op_e'(4'd15), '1, 0, 0, 0));
    pending_q.push_back(make_request(abt_pkg::OP_CLEAR, '0, 0, 0, 0));
    // Fill the subnet table past capacity to hit the full status.
    for (int i = 0; i < NS + 2; i++)
      pending_q.push_back(make_request(abt_pkg::OP_BAN_SUB, rand_addr(), 8'd64, 5, 0));
    wait_idle();

    // Random phases with various maximum durations and idle rates.
    t = 48'd1000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_max_duration(40'd0);
        1: write_max_duration(40'hFF_FFFF_FFFF);
        2: write_max_duration(40'd1);
        3: write_max_duration(40'd500);
        default: write_max_duration(40'($urandom_range(2000, 1)));
      endcase
      sender_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 46 : 13);
      if (ph == 1) t = 48'hFFFF_FFFF_FF00;
      else if (ph == 2) t = 48'd0;
      for (int i = 0; i < 58; i++) begin
        t = t + $urandom_range(60);
        if (i == 40 && ph == 4) begin
          // Flood the address table to reach the full status.
          for (int j = 0; j < NA + 2; j++)
            pending_q.push_back(make_request(abt_pkg::OP_BAN_ADDR, rand_addr(), 0, 0, t));
        end
        pending_q.push_back(random_request(t));
      end
      wait_idle();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
